@@ design/view_transform_matrix_builder_macros.svh @@
// ----------------------------------------------------------------------------
// View transform matrix builder assertion macros
// Shared concurrent assertion forms, clocked on i_clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef VIEW_TRANSFORM_MATRIX_BUILDER_MACROS_SVH
`define VIEW_TRANSFORM_MATRIX_BUILDER_MACROS_SVH

// same-cycle implication
`define VTMB_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("vtmb assertion failed");

// next-cycle implication
`define VTMB_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("vtmb assertion failed");

`endif

@@ design/vtmb_pkg.sv @@
// ----------------------------------------------------------------------------
// vtmb_pkg
// Types, widths and arithmetic helpers of the look-at view matrix builder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vtmb_pkg;

    localparam int IN_FRAC_BITS  = 16;
    localparam int OUT_FRAC_BITS = 30;
    localparam int UNIT_FRAC     = 30;

    localparam int COORD_W = 32;
    localparam int ENTRY_W = 48;
    localparam int MAG_W   = COORD_W + 1;
    localparam int NRM_W   = UNIT_FRAC + 1;
    localparam int SQ_W    = 2 * NRM_W;
    localparam int SUM_W   = 64;
    localparam int ROOT_W  = SUM_W / 2;
    localparam int SR_W    = ROOT_W + 4;
    localparam int QUO_W   = UNIT_FRAC + 1;
    localparam int NUM_W   = NRM_W + UNIT_FRAC + 1;
    localparam int PROD_W  = 2 * COORD_W;
    localparam int DOT_W   = PROD_W + 2;

    localparam int SQRT_STAGES = ROOT_W;
    localparam int DIV_STAGES  = QUO_W;
    localparam int UNIT_LAT    = 4 + SQRT_STAGES + 1 + DIV_STAGES + 1;
    localparam int CROSS_LAT   = 2;

    localparam logic [1:0] ROW_LAST = 2'd3;

    localparam logic signed [DOT_W-1:0] SAT_HI = (DOT_W'(1) <<< (ENTRY_W - 1)) - DOT_W'(1);
    localparam logic signed [DOT_W-1:0] SAT_LO = -(DOT_W'(1) <<< (ENTRY_W - 1));
    localparam logic signed [ENTRY_W-1:0] ONE_OUT = ENTRY_W'(1) <<< OUT_FRAC_BITS;
    localparam logic signed [COORD_W+1:0] CLAMP_HI = (COORD_W+2)'(1) <<< UNIT_FRAC;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_vec;

    typedef struct packed {
        logic signed [COORD_W-1:0] eye_x;
        logic signed [COORD_W-1:0] eye_y;
        logic signed [COORD_W-1:0] eye_z;
        logic signed [COORD_W-1:0] target_x;
        logic signed [COORD_W-1:0] target_y;
        logic signed [COORD_W-1:0] target_z;
        logic signed [COORD_W-1:0] up_hint_x;
        logic signed [COORD_W-1:0] up_hint_y;
        logic signed [COORD_W-1:0] up_hint_z;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]                row_index;
        logic signed [ENTRY_W-1:0] entry_c0;
        logic signed [ENTRY_W-1:0] entry_c1;
        logic signed [ENTRY_W-1:0] entry_c2;
        logic signed [ENTRY_W-1:0] entry_c3;
        logic                      last_row;
        logic                      degenerate;
    } t_out_beat;

    function automatic logic signed [PROD_W-1:0] smul(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        return a * b;
    endfunction

    // round half up to Q.30, clamp to [-1.0, 1.0]
    function automatic logic signed [COORD_W-1:0] cross_term(
        input logic signed [PROD_W-1:0] p,
        input logic signed [PROD_W-1:0] q
    );
        logic signed [PROD_W-1:0]  d;
        logic signed [COORD_W+1:0] r;
        d = p - q + (PROD_W'(1) <<< (UNIT_FRAC - 1));
        r = (COORD_W+2)'(d >>> UNIT_FRAC);
        if (r > CLAMP_HI) begin
            r = CLAMP_HI;
        end else if (r < -CLAMP_HI) begin
            r = -CLAMP_HI;
        end
        return COORD_W'(r);
    endfunction

    // move from from_f fraction bits to OUT_FRAC_BITS, saturate to the entry range
    function automatic logic signed [ENTRY_W-1:0] rescale(
        input logic signed [DOT_W-1:0] x,
        input int                      from_f
    );
        int                      k;
        logic signed [DOT_W-1:0] r;
        logic signed [ENTRY_W-1:0] res;
        if (OUT_FRAC_BITS >= from_f) begin
            k = OUT_FRAC_BITS - from_f;
            if (x > (SAT_HI >>> k)) begin
                res = SAT_HI[ENTRY_W-1:0];
            end else if (x < -(DOT_W'(1) <<< (ENTRY_W - 1 - k))) begin
                res = SAT_LO[ENTRY_W-1:0];
            end else begin
                r   = x <<< k;
                res = r[ENTRY_W-1:0];
            end
        end else begin
            k = from_f - OUT_FRAC_BITS;
            r = (x + (DOT_W'(1) <<< (k - 1))) >>> k;
            if (r > SAT_HI) begin
                res = SAT_HI[ENTRY_W-1:0];
            end else if (r < SAT_LO) begin
                res = SAT_LO[ENTRY_W-1:0];
            end else begin
                res = r[ENTRY_W-1:0];
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ design/vtmb_unit.sv @@
// ----------------------------------------------------------------------------
// vtmb_unit
// Pipelined vector normaliser: magnitude, range shift, sum of squares,
// one root bit per stage, one quotient bit per stage, sign restore.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vtmb_unit
    import vtmb_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_en,
    input  wire logic                    i_vld,
    input  wire logic signed [MAG_W-1:0] i_comp [3],
    output logic                         o_vld,
    output logic                         o_zero,
    output t_vec                         o_unit
);

    logic             r1_vld;
    logic [MAG_W-1:0] r1_mag [3];
    logic [2:0]       r1_neg;

    logic [MAG_W-1:0] n2_or;
    logic [5:0]       n2_msb;
    logic [NRM_W-1:0] n2_ms [3];

    logic             r2_vld;
    logic [NRM_W-1:0] r2_ms [3];
    logic [2:0]       r2_neg;
    logic             r2_zero;

    logic             r3_vld;
    logic [SQ_W-1:0]  r3_sq [3];
    logic [NRM_W-1:0] r3_ms [3];
    logic [2:0]       r3_neg;
    logic             r3_zero;

    logic              r_sr_vld  [SQRT_STAGES+1];
    logic [SR_W-1:0]   r_sr_rem  [SQRT_STAGES+1];
    logic [ROOT_W-1:0] r_sr_root [SQRT_STAGES+1];
    logic [SUM_W-1:0]  r_sr_val  [SQRT_STAGES+1];
    logic [NRM_W-1:0]  r_sr_ms   [SQRT_STAGES+1][3];
    logic [2:0]        r_sr_neg  [SQRT_STAGES+1];
    logic              r_sr_zero [SQRT_STAGES+1];

    logic [NUM_W-1:0]  n_num [3];

    logic              r_dv_vld  [DIV_STAGES+1];
    logic [ROOT_W-1:0] r_dv_len  [DIV_STAGES+1];
    logic [ROOT_W-1:0] r_dv_rem  [DIV_STAGES+1][3];
    logic [QUO_W-1:0]  r_dv_low  [DIV_STAGES+1][3];
    logic [QUO_W-1:0]  r_dv_q    [DIV_STAGES+1][3];
    logic [2:0]        r_dv_neg  [DIV_STAGES+1];
    logic              r_dv_zero [DIV_STAGES+1];

    logic r_out_vld;
    logic r_out_zero;
    t_vec r_out_unit;

    // magnitudes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r1_neg[i] <= i_comp[i][MAG_W-1];
                r1_mag[i] <= i_comp[i][MAG_W-1] ? MAG_W'(-i_comp[i]) : MAG_W'(i_comp[i]);
            end
        end
    end

    // bring the largest magnitude into [2^30, 2^31)
    always_comb begin
        n2_or  = r1_mag[0] | r1_mag[1] | r1_mag[2];
        n2_msb = '0;
        for (int b = 0; b < MAG_W; b++) begin
            if (n2_or[b]) begin
                n2_msb = 6'(b);
            end
        end
        for (int i = 0; i < 3; i++) begin
            if (n2_msb >= 6'(NRM_W)) begin
                n2_ms[i] = NRM_W'(r1_mag[i] >> (n2_msb - 6'(NRM_W - 1)));
            end else begin
                n2_ms[i] = NRM_W'(r1_mag[i] << (6'(NRM_W - 1) - n2_msb));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_ms   <= n2_ms;
            r2_neg  <= r1_neg;
            r2_zero <= (n2_or == '0);
            for (int i = 0; i < 3; i++) begin
                r3_sq[i] <= SQ_W'(r2_ms[i]) * SQ_W'(r2_ms[i]);
            end
            r3_ms   <= r2_ms;
            r3_neg  <= r2_neg;
            r3_zero <= r2_zero;
        end
    end

    // sum of squares, root stage zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sr_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_sr_vld[0] <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sr_rem[0]  <= '0;
            r_sr_root[0] <= '0;
            r_sr_val[0]  <= SUM_W'(r3_sq[0]) + SUM_W'(r3_sq[1]) + SUM_W'(r3_sq[2]);
            r_sr_ms[0]   <= r3_ms;
            r_sr_neg[0]  <= r3_neg;
            r_sr_zero[0] <= r3_zero;
        end
    end

    for (genvar k = 1; k <= SQRT_STAGES; k++) begin : g_sqrt
        logic [SR_W-1:0]   n_sh;
        logic [SR_W-1:0]   n_trial;
        logic [SR_W-1:0]   n_rem;
        logic [ROOT_W-1:0] n_root;

        always_comb begin
            n_sh    = {r_sr_rem[k-1][SR_W-3:0], r_sr_val[k-1][SUM_W-1 -: 2]};
            n_trial = SR_W'({r_sr_root[k-1], 2'b01});
            if (n_sh >= n_trial) begin
                n_rem  = n_sh - n_trial;
                n_root = {r_sr_root[k-1][ROOT_W-2:0], 1'b1};
            end else begin
                n_rem  = n_sh;
                n_root = {r_sr_root[k-1][ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sr_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_sr_vld[k] <= r_sr_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sr_rem[k]  <= n_rem;
                r_sr_root[k] <= n_root;
                r_sr_val[k]  <= r_sr_val[k-1] << 2;
                r_sr_ms[k]   <= r_sr_ms[k-1];
                r_sr_neg[k]  <= r_sr_neg[k-1];
                r_sr_zero[k] <= r_sr_zero[k-1];
            end
        end
    end

    // dividend m * 2^30 + len / 2
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_num[i] = (NUM_W'(r_sr_ms[SQRT_STAGES][i]) << UNIT_FRAC)
                     + NUM_W'(r_sr_root[SQRT_STAGES] >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_dv_vld[0] <= r_sr_vld[SQRT_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dv_len[0] <= r_sr_root[SQRT_STAGES];
            for (int i = 0; i < 3; i++) begin
                r_dv_rem[0][i] <= ROOT_W'(n_num[i][NUM_W-1:QUO_W]);
                r_dv_low[0][i] <= n_num[i][QUO_W-1:0];
                r_dv_q[0][i]   <= '0;
            end
            r_dv_neg[0]  <= r_sr_neg[SQRT_STAGES];
            r_dv_zero[0] <= r_sr_zero[SQRT_STAGES];
        end
    end

    for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
        logic [ROOT_W:0]   n_sh  [3];
        logic [ROOT_W-1:0] n_rem [3];
        logic [2:0]        n_bit;

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                n_sh[i] = {r_dv_rem[k-1][i], r_dv_low[k-1][i][QUO_W-1]};
                if (n_sh[i] >= {1'b0, r_dv_len[k-1]}) begin
                    n_rem[i] = ROOT_W'(n_sh[i] - {1'b0, r_dv_len[k-1]});
                    n_bit[i] = 1'b1;
                end else begin
                    n_rem[i] = ROOT_W'(n_sh[i]);
                    n_bit[i] = 1'b0;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_dv_vld[k] <= r_dv_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv_len[k] <= r_dv_len[k-1];
                for (int i = 0; i < 3; i++) begin
                    r_dv_rem[k][i] <= n_rem[i];
                    r_dv_low[k][i] <= r_dv_low[k-1][i] << 1;
                    r_dv_q[k][i]   <= {r_dv_q[k-1][i][QUO_W-2:0], n_bit[i]};
                end
                r_dv_neg[k]  <= r_dv_neg[k-1];
                r_dv_zero[k] <= r_dv_zero[k-1];
            end
        end
    end

    // restore signs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_out_vld <= r_dv_vld[DIV_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out_zero   <= r_dv_zero[DIV_STAGES];
            r_out_unit.x <= r_dv_neg[DIV_STAGES][0] ? -COORD_W'(r_dv_q[DIV_STAGES][0])
                                                    :  COORD_W'(r_dv_q[DIV_STAGES][0]);
            r_out_unit.y <= r_dv_neg[DIV_STAGES][1] ? -COORD_W'(r_dv_q[DIV_STAGES][1])
                                                    :  COORD_W'(r_dv_q[DIV_STAGES][1]);
            r_out_unit.z <= r_dv_neg[DIV_STAGES][2] ? -COORD_W'(r_dv_q[DIV_STAGES][2])
                                                    :  COORD_W'(r_dv_q[DIV_STAGES][2]);
        end
    end

    assign o_vld  = r_out_vld;
    assign o_zero = r_out_zero;
    assign o_unit = r_out_unit;

endmodule

`default_nettype wire

@@ design/vtmb_cross.sv @@
// ----------------------------------------------------------------------------
// vtmb_cross
// Two-stage cross product of Q1.30 vectors: products, then difference,
// rounding and clamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vtmb_cross
    import vtmb_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_en,
    input  wire logic i_vld,
    input  wire t_vec i_a,
    input  wire t_vec i_b,
    output logic      o_vld,
    output t_vec      o_c
);

    logic                     r1_vld;
    logic signed [PROD_W-1:0] r1_p [6];
    logic                     r2_vld;
    t_vec                     r2_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_p[0] <= smul(i_a.y, i_b.z);
            r1_p[1] <= smul(i_a.z, i_b.y);
            r1_p[2] <= smul(i_a.z, i_b.x);
            r1_p[3] <= smul(i_a.x, i_b.z);
            r1_p[4] <= smul(i_a.x, i_b.y);
            r1_p[5] <= smul(i_a.y, i_b.x);
            r2_c.x  <= cross_term(r1_p[0], r1_p[1]);
            r2_c.y  <= cross_term(r1_p[2], r1_p[3]);
            r2_c.z  <= cross_term(r1_p[4], r1_p[5]);
        end
    end

    assign o_vld = r2_vld;
    assign o_c   = r2_c;

endmodule

`default_nettype wire

@@ design/vtmb_rows.sv @@
// ----------------------------------------------------------------------------
// vtmb_rows
// Eye dot products, rescale and saturation of the entries of rows 0 to 2, and the row
// serialiser that drives the output channel one row per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "view_transform_matrix_builder_macros.svh"

module vtmb_rows
    import vtmb_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_en,
    input  wire logic  i_vld,
    input  wire logic  i_zero,
    input  wire t_vec  i_lf,
    input  wire t_vec  i_tu,
    input  wire t_vec  i_fw,
    input  wire t_vec  i_eye,
    output logic       o_en,
    output logic       o_out_valid,
    input  wire logic  i_out_ready,
    output t_out_beat  o_out_data
);

    logic signed [COORD_W-1:0] w_v   [3][3];
    logic signed [COORD_W-1:0] w_eye [3];

    logic                      r1_vld;
    logic                      r1_zero;
    logic signed [COORD_W-1:0] r1_v [3][3];
    logic signed [PROD_W-1:0]  r1_p [3][3];

    logic                      r2_vld;
    logic                      r2_zero;
    logic signed [COORD_W-1:0] r2_v   [3][3];
    logic signed [DOT_W-1:0]   r2_dot [3];

    logic signed [ENTRY_W-1:0] n3_e [3][4];
    logic                      r3_vld;
    logic                      r3_zero;
    logic signed [ENTRY_W-1:0] r3_e [3][4];

    logic                      r_ser_vld;
    logic                      r_ser_zero;
    logic [1:0]                r_row;
    logic signed [ENTRY_W-1:0] r_ser_e [4][4];

    logic w_en;

    always_comb begin
        w_v[0][0] = i_lf.x;
        w_v[0][1] = i_lf.y;
        w_v[0][2] = i_lf.z;
        w_v[1][0] = i_tu.x;
        w_v[1][1] = i_tu.y;
        w_v[1][2] = i_tu.z;
        w_v[2][0] = i_fw.x;
        w_v[2][1] = i_fw.y;
        w_v[2][2] = i_fw.z;
        w_eye[0]  = i_eye.x;
        w_eye[1]  = i_eye.y;
        w_eye[2]  = i_eye.z;
    end

    assign w_en = !r_ser_vld || (i_out_ready && r_row == ROW_LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_zero <= i_zero;
            r1_v    <= w_v;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r1_p[r][c] <= smul(w_v[r][c], w_eye[c]);
                end
            end
            r2_zero <= r1_zero;
            r2_v    <= r1_v;
            for (int r = 0; r < 3; r++) begin
                r2_dot[r] <= DOT_W'(r1_p[r][0]) + DOT_W'(r1_p[r][1]) + DOT_W'(r1_p[r][2]);
            end
            r3_zero <= r2_zero;
            r3_e    <= n3_e;
        end
    end

    // negate forward in the third row and the dot in the first two; zeros if degenerate
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if (r2_zero) begin
                    n3_e[r][c] = '0;
                end else if (r == 2) begin
                    n3_e[r][c] = rescale(-DOT_W'(r2_v[r][c]), UNIT_FRAC);
                end else begin
                    n3_e[r][c] = rescale(DOT_W'(r2_v[r][c]), UNIT_FRAC);
                end
            end
            if (r2_zero) begin
                n3_e[r][3] = '0;
            end else if (r == 2) begin
                n3_e[r][3] = rescale(r2_dot[r], UNIT_FRAC + IN_FRAC_BITS);
            end else begin
                n3_e[r][3] = rescale(-r2_dot[r], UNIT_FRAC + IN_FRAC_BITS);
            end
        end
    end

    // row serialiser
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ser_vld <= 1'b0;
            r_row     <= '0;
        end else if (w_en) begin
            r_ser_vld <= r3_vld;
            r_row     <= '0;
        end else if (i_out_ready) begin
            r_row <= r_row + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ser_zero <= r3_zero;
            for (int r = 0; r < 3; r++) begin
                r_ser_e[r] <= r3_e[r];
            end
            r_ser_e[3][0] <= '0;
            r_ser_e[3][1] <= '0;
            r_ser_e[3][2] <= '0;
            r_ser_e[3][3] <= ONE_OUT;
        end
    end

    always_comb begin
        o_out_data.row_index  = r_row;
        o_out_data.entry_c0   = r_ser_e[r_row][0];
        o_out_data.entry_c1   = r_ser_e[r_row][1];
        o_out_data.entry_c2   = r_ser_e[r_row][2];
        o_out_data.entry_c3   = r_ser_e[r_row][3];
        o_out_data.last_row   = (r_row == ROW_LAST);
        o_out_data.degenerate = r_ser_zero;
    end

    assign o_out_valid = r_ser_vld;
    assign o_en        = w_en;

    `VTMB_ASSERT_IMP(a_last_on_row3, o_out_valid && o_out_data.row_index == ROW_LAST, o_out_data.last_row)
    `VTMB_ASSERT_NXT(a_row_advance, o_out_valid && i_out_ready && r_row != ROW_LAST, o_out_valid && r_row == $past(r_row) + 2'd1)
    `VTMB_ASSERT_NXT(a_hold_on_stall, r_ser_vld && !i_out_ready, r_ser_vld && $stable(r_row))
    `VTMB_ASSERT_IMP(a_degen_zero, o_out_valid && o_out_data.degenerate && r_row != ROW_LAST, o_out_data.entry_c0 == '0 && o_out_data.entry_c1 == '0 && o_out_data.entry_c2 == '0 && o_out_data.entry_c3 == '0)

endmodule

`default_nettype wire

@@ design/view_transform_matrix_builder.sv @@
// Output: each item leaves as rows 0 to 3 in order, row by row as the sink is
// ready. The pipeline takes a beat each cycle while the row serialiser is empty
// or hands its last row to a ready sink, and otherwise stalls as a whole.
// Reset: synchronous, active low; clears every valid bit and the row counter.
// ----------------------------------------------------------------------------
// view_transform_matrix_builder
// Look-at view matrix: normalise forward and up, two cross products, eye
// dot products, then four matrix rows per item on the output channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module view_transform_matrix_builder
    import vtmb_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_beat i_in_data,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_out_beat     o_out_data
);

    localparam int EYE_DLY = UNIT_LAT + 2 * CROSS_LAT;

    logic                    w_en;
    logic signed [MAG_W-1:0] w_dir [3];
    logic signed [MAG_W-1:0] w_up  [3];

    logic w_fw_vld;
    logic w_fw_zero;
    t_vec w_fw;
    logic w_up_vld;
    logic w_up_zero;
    t_vec w_un;

    logic w_lf_vld;
    t_vec w_lf;
    logic w_tu_vld;
    t_vec w_tu;

    t_vec r_eye_dly  [EYE_DLY];
    t_vec r_fw_dly   [2*CROSS_LAT];
    t_vec r_lf_dly   [CROSS_LAT];
    logic r_zero_dly [2*CROSS_LAT];
    t_vec w_eye_in;

    always_comb begin
        w_dir[0] = MAG_W'(i_in_data.target_x) - MAG_W'(i_in_data.eye_x);
        w_dir[1] = MAG_W'(i_in_data.target_y) - MAG_W'(i_in_data.eye_y);
        w_dir[2] = MAG_W'(i_in_data.target_z) - MAG_W'(i_in_data.eye_z);
        w_up[0]  = MAG_W'(i_in_data.up_hint_x);
        w_up[1]  = MAG_W'(i_in_data.up_hint_y);
        w_up[2]  = MAG_W'(i_in_data.up_hint_z);
        w_eye_in.x = i_in_data.eye_x;
        w_eye_in.y = i_in_data.eye_y;
        w_eye_in.z = i_in_data.eye_z;
    end

    vtmb_unit u_fwd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_in_valid),
        .i_comp  (w_dir),
        .o_vld   (w_fw_vld),
        .o_zero  (w_fw_zero),
        .o_unit  (w_fw)
    );

    vtmb_unit u_up (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_in_valid),
        .i_comp  (w_up),
        .o_vld   (w_up_vld),
        .o_zero  (w_up_zero),
        .o_unit  (w_un)
    );

    vtmb_cross u_left (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_fw_vld && w_up_vld),
        .i_a     (w_fw),
        .i_b     (w_un),
        .o_vld   (w_lf_vld),
        .o_c     (w_lf)
    );

    vtmb_cross u_true_up (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_lf_vld),
        .i_a     (w_lf),
        .i_b     (r_fw_dly[CROSS_LAT-1]),
        .o_vld   (w_tu_vld),
        .o_c     (w_tu)
    );

    // align eye, forward, left and the degenerate flag with true_up
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_eye_dly[0]  <= w_eye_in;
            r_fw_dly[0]   <= w_fw;
            r_lf_dly[0]   <= w_lf;
            r_zero_dly[0] <= w_fw_zero || w_up_zero;
            for (int k = 1; k < EYE_DLY; k++) begin
                r_eye_dly[k] <= r_eye_dly[k-1];
            end
            for (int k = 1; k < 2 * CROSS_LAT; k++) begin
                r_fw_dly[k]   <= r_fw_dly[k-1];
                r_zero_dly[k] <= r_zero_dly[k-1];
            end
            for (int k = 1; k < CROSS_LAT; k++) begin
                r_lf_dly[k] <= r_lf_dly[k-1];
            end
        end
    end

    vtmb_rows u_rows (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_vld       (w_tu_vld),
        .i_zero      (r_zero_dly[2*CROSS_LAT-1]),
        .i_lf        (r_lf_dly[CROSS_LAT-1]),
        .i_tu        (w_tu),
        .i_fw        (r_fw_dly[2*CROSS_LAT-1]),
        .i_eye       (r_eye_dly[EYE_DLY-1]),
        .o_en        (w_en),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    assign o_in_ready = w_en;

endmodule

`default_nettype wire
